FILE: sv/sfm_pkg.sv
// ============================================================================
// sfm_pkg
// Shared types and constants of the substring first-match search block.
// ============================================================================
package sfm_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int PAT_WORDS   = 4;
    localparam int PAT_BYTES   = 32;
    localparam int WORD_BYTES  = WORD_W / BYTE_W;
    localparam int EXT_BYTES   = 64;    // largest supported window
    localparam int LENGTH_W    = 6;
    localparam int INDEX_W     = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int ITEM_QUEUE_DEPTH   = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_TOO_LONG  = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              byte_valid;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] match_index;
    } result_t;

endpackage

FILE: sv/substring_first_match.sv
// ============================================================================
// substring_first_match: first match of a configured pattern in a byte stream
// Path: an item is registered in the item queue, compared, and its result registered in the result queue.
// Throughput: one text byte per cycle while the result queue has room, set by the combinational window compare.
// Pattern writes reach the compare through the configuration registers and then the aligned pattern registers.
// Reset (rst_n, async): queues empty, counters, window and registers cleared.
// ============================================================================
module substring_first_match #(
    parameter int              MAX_PATTERN = 32,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sfm_pkg::BYTE_W-1:0]        text_byte,
    input  logic                              byte_valid,
    input  logic                              last_byte,
    input  logic                              push,
    output logic                              full,
    output logic [1:0]                        status,
    output logic [sfm_pkg::INDEX_W-1:0]       match_index,
    output logic                              empty,
    input  logic                              pop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfm_pkg::WORD_W-1:0]        cfg_data
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ITEM_W = $bits(sfm_pkg::item_t);
    localparam int RES_W  = $bits(sfm_pkg::result_t);

    logic                                        pattern_empty;
    logic [LEN_W-1:0]                            eff_len;
    logic [MAX_PATTERN-1:0]                      care;
    logic [MAX_PATTERN-1:0][sfm_pkg::BYTE_W-1:0] aligned;

    sfm_pkg::item_t   in_item, q_item;
    logic [ITEM_W-1:0] q_item_bits;
    logic             accept, keep, item_empty, item_pop;
    sfm_pkg::result_t res_data, out_res;
    logic [RES_W-1:0] out_bits;
    logic             res_push, res_full;

    sfm_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pattern_empty (pattern_empty),
        .eff_len       (eff_len),
        .care          (care),
        .aligned       (aligned)
    );

    // front: an empty marker that does not end the text only matters when
    // the empty pattern answers on the first item, so drop it otherwise
    assign in_item.text_byte  = text_byte;
    assign in_item.byte_valid = byte_valid;
    assign in_item.last_byte  = last_byte;
    assign accept             = push && !full;
    assign keep               = byte_valid || last_byte || pattern_empty;

    sfm_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (sfm_pkg::ITEM_QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept && keep),
        .wr_data (in_item),
        .full    (full),
        .pop     (item_pop),
        .rd_data (q_item_bits),
        .empty   (item_empty)
    );

    assign q_item = sfm_pkg::item_t'(q_item_bits);

    sfm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .eff_len    (eff_len),
        .care       (care),
        .aligned    (aligned),
        .res_push   (res_push),
        .res_data   (res_data),
        .res_full   (res_full)
    );

    sfm_queue #(
        .WIDTH (RES_W),
        .DEPTH (sfm_pkg::RESULT_QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_bits),
        .empty   (empty)
    );

    assign out_res     = sfm_pkg::result_t'(out_bits);
    assign status      = out_res.status;
    assign match_index = out_res.match_index;

endmodule

FILE: sv/sfm_queue.sv
// ============================================================================
// sfm_queue
// Small synchronous FIFO with full/empty flags; depth is a power of two.
// ============================================================================
module sfm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/sfm_cfg.sv
// ============================================================================
// sfm_cfg
// Configuration registers and the pattern aligned to the byte window.
// ============================================================================
module sfm_cfg #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [sfm_pkg::WORD_W-1:0]                 cfg_data,
    output logic                                       pattern_empty,
    output logic [$clog2(MAX_PATTERN+1)-1:0]           eff_len,
    output logic [MAX_PATTERN-1:0]                     care,
    output logic [MAX_PATTERN-1:0][sfm_pkg::BYTE_W-1:0] aligned
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int EB    = sfm_pkg::EXT_BYTES;
    localparam int BW    = sfm_pkg::BYTE_W;

    logic [sfm_pkg::LENGTH_W-1:0]  length_reg;
    logic [sfm_pkg::WORD_W-1:0]    word_reg [sfm_pkg::PAT_WORDS];
    logic                          wr_en;

    logic [6:0]                    len7;
    logic [6:0]                    eff7;
    logic [6:0]                    shift_bytes;
    logic [EB-1:0][BW-1:0]         pat_ext;
    logic [EB-1:0][BW-1:0]         pat_rev;
    logic [EB*BW-1:0]              pat_shifted;
    logic [MAX_PATTERN-1:0]        care_next;

    logic [LEN_W-1:0]                   eff_len_reg;
    logic [MAX_PATTERN-1:0]             care_reg;
    logic [MAX_PATTERN-1:0][BW-1:0]     aligned_reg;

    assign cfg_ready     = 1'b1;
    assign wr_en         = cfg_valid && cfg_ready;
    assign pattern_empty = (length_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            for (int w = 0; w < sfm_pkg::PAT_WORDS; w++)
            begin
                word_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                sfm_pkg::CFG_PATTERN_LENGTH: length_reg  <= cfg_data[sfm_pkg::LENGTH_W-1:0];
                sfm_pkg::CFG_PATTERN_WORD_0: word_reg[0] <= cfg_data;
                sfm_pkg::CFG_PATTERN_WORD_1: word_reg[1] <= cfg_data;
                sfm_pkg::CFG_PATTERN_WORD_2: word_reg[2] <= cfg_data;
                sfm_pkg::CFG_PATTERN_WORD_3: word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // length saturates at the window size
    assign len7 = {1'b0, length_reg};
    assign eff7 = (len7 > 7'(MAX_PATTERN)) ? 7'(MAX_PATTERN) : len7;

    // byte k of the window lines up with pattern byte len-1-k: reverse the
    // pattern, then shift it down by (EB - len) bytes
    for (genvar j = 0; j < EB; j++)
    begin : g_ext
        if (j < sfm_pkg::PAT_BYTES)
        begin : g_pat
            assign pat_ext[j] =
                word_reg[j / sfm_pkg::WORD_BYTES][(j % sfm_pkg::WORD_BYTES) * BW +: BW];
        end
        else
        begin : g_zero
            assign pat_ext[j] = '0;
        end
        assign pat_rev[j] = pat_ext[EB-1-j];
    end

    assign shift_bytes = 7'(EB) - eff7;
    assign pat_shifted = pat_rev >> {shift_bytes, 3'b000};

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_care
        assign care_next[k] = (7'(k) < eff7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= '0;
            care_reg    <= '0;
            aligned_reg <= '0;
        end
        else
        begin
            eff_len_reg <= LEN_W'(eff7);
            care_reg    <= care_next;
            aligned_reg <= pat_shifted[MAX_PATTERN*BW-1:0];
        end
    end

    assign eff_len = eff_len_reg;
    assign care    = care_reg;
    assign aligned = aligned_reg;

endmodule

FILE: sv/sfm_back.sv
// ============================================================================
// sfm_back
// Byte window, text counter and window compare; one item per cycle while the result queue is not full.
// ============================================================================
module sfm_back #(
    parameter int              MAX_PATTERN = 32,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  sfm_pkg::item_t                              item,
    input  logic                                        item_empty,
    output logic                                        item_pop,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]            eff_len,
    input  logic [MAX_PATTERN-1:0]                      care,
    input  logic [MAX_PATTERN-1:0][sfm_pkg::BYTE_W-1:0] aligned,
    output logic                                        res_push,
    output sfm_pkg::result_t                            res_data,
    input  logic                                        res_full
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int SEEN_W = $clog2(MAX_TEXT + 1);
    localparam int CMP_W  = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
    localparam int BW     = sfm_pkg::BYTE_W;

    logic [MAX_PATTERN-1:0][BW-1:0] window_reg, window_next, shifted;
    logic [SEEN_W-1:0]              seen_reg, seen_next, seen_inc, seen_after;
    logic                           answered_reg, answered_next;
    logic [MAX_PATTERN-1:0]         hit;
    logic                           window_match;
    logic                           overflow;
    logic                           fire;
    logic                           emit;
    logic [CMP_W-1:0]               start_index;

    assign fire     = !item_empty && !res_full;
    assign item_pop = fire;

    always_comb
    begin
        shifted[0] = item.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            shifted[k] = window_reg[k-1];
        end
    end

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cmp
        assign hit[k] = !care[k] || (shifted[k] == aligned[k]);
    end

    assign window_match = &hit;
    assign seen_inc     = seen_reg + 1'b1;
    assign overflow     = (seen_reg >= SEEN_W'(MAX_TEXT));
    assign start_index  = CMP_W'(seen_inc) - CMP_W'(eff_len);

    always_comb
    begin
        window_next          = window_reg;
        seen_next            = seen_reg;
        seen_after           = seen_reg;
        answered_next        = answered_reg;
        emit                 = 1'b0;
        res_data.status      = sfm_pkg::STATUS_FOUND;
        res_data.match_index = '0;
        if (fire)
        begin
            if (!answered_reg)
            begin
                if (eff_len == '0)
                begin
                    emit = 1'b1;
                end
                else if (item.byte_valid)
                begin
                    if (overflow)
                    begin
                        emit            = 1'b1;
                        res_data.status = sfm_pkg::STATUS_OVERFLOW;
                    end
                    else
                    begin
                        window_next = shifted;
                        seen_after  = seen_inc;
                        if ((CMP_W'(seen_inc) >= CMP_W'(eff_len)) && window_match)
                        begin
                            emit                 = 1'b1;
                            res_data.match_index = sfm_pkg::INDEX_W'(start_index);
                        end
                    end
                end
                if (!emit && item.last_byte)
                begin
                    emit            = 1'b1;
                    res_data.status = (CMP_W'(eff_len) > CMP_W'(seen_after))
                                    ? sfm_pkg::STATUS_TOO_LONG
                                    : sfm_pkg::STATUS_NOT_FOUND;
                end
            end
            if (item.last_byte)
            begin
                seen_next     = '0;
                answered_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_after;
                answered_next = answered_reg || emit;
            end
        end
    end

    assign res_push = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            seen_reg     <= '0;
            answered_reg <= 1'b0;
        end
        else
        begin
            window_reg   <= window_next;
            seen_reg     <= seen_next;
            answered_reg <= answered_next;
        end
    end

endmodule
